### hdl/assert_macros.svh
// Assertion macros shared by the intel hex decoder modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge of clk while out of reset.
`define IHEX_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the antecedent implies the consequent in the following cycle.
`define IHEX_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/ihex_pkg.sv
// Types and constants shared by the intel hex record decoder.
package ihex_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] HEX_TEN  = 8'd10;

  typedef enum logic [2:0] {
    K_DATA     = 3'd0,
    K_END      = 3'd1,
    K_CSUM     = 3'd2,
    K_UNKNOWN  = 3'd3,
    K_BADDIGIT = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_LEN  = 3'd1,
    PH_AHI  = 3'd2,
    PH_ALO  = 3'd3,
    PH_TYPE = 3'd4,
    PH_DATA = 3'd5,
    PH_CSUM = 3'd6
  } phase_t;

  localparam logic [7:0] REC_TYPE_DATA = 8'h00;
  localparam logic [7:0] REC_TYPE_EOF  = 8'h01;

  // One classified character.
  typedef struct packed {
    logic       colon;
    logic       bad;
    logic [3:0] nib;
  } tok_t;

endpackage

### hdl/ihex_ifs.sv
// Stream interfaces for the character input and the decoded result output.
interface ihex_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_rec_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [15:0] address;
  logic [7:0]  data;
  logic        digit_bad;

  modport source (output valid, output kind, output address, output data,
                  output digit_bad, input ready);
  modport sink   (input valid, input kind, input address, input data,
                  input digit_bad, output ready);
endinterface

### hdl/ihex_front.sv
// Front end: accept characters, classify them as hex digits, hold one token.
module ihex_front (
  input  logic          clk,
  input  logic          rst_n,
  ihex_char_if.sink     in_ch,
  output logic          push_valid,
  input  logic          push_ready,
  output ihex_pkg::tok_t push_tok
);
  import ihex_pkg::*;

  logic tok_v_r;
  tok_t tok_r;
  tok_t tok_nxt;
  logic take;
  logic push;

  always_comb begin
    logic [7:0] c;
    c = in_ch.char_in;
    tok_nxt.colon = (c == CH_COLON);
    tok_nxt.bad   = 1'b0;
    tok_nxt.nib   = '0;
    if (c >= CH_0 && c <= CH_9) begin
      tok_nxt.nib = 4'(c - CH_0);
    end else if (c >= CH_UA && c <= CH_UF) begin
      tok_nxt.nib = 4'(c - CH_UA + HEX_TEN);
    end else if (c >= CH_LA && c <= CH_LF) begin
      tok_nxt.nib = 4'(c - CH_LA + HEX_TEN);
    end else begin
      tok_nxt.bad = 1'b1;
    end
  end

  assign push        = tok_v_r && push_ready;
  assign in_ch.ready = !tok_v_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;
  assign push_valid  = tok_v_r;
  assign push_tok    = tok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_v_r <= 1'b0;
    end else if (take) begin
      tok_v_r <= 1'b1;
    end else if (push) begin
      tok_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tok_r <= tok_nxt;
    end
  end

endmodule

### hdl/ihex_queue.sv
// Short token queue between the classifier and the record engine.
module ihex_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ihex_pkg::tok_t push_tok,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ihex_pkg::tok_t pop_tok
);
  import ihex_pkg::*;
  `include "assert_macros.svh"

  tok_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              push;
  logic              pop;

  assign push_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

  `IHEX_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= QCNT_W'(QDEPTH), "queue count past depth")
  `IHEX_ASSERT(a_ptr_gap, clk, rst_n, QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(cnt_r), "queue pointers disagree with count")

endmodule

### hdl/ihex_back.sv
// Record engine: track record phase, byte assembly, address and sum; emit results.
module ihex_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  ihex_pkg::tok_t pop_tok,
  ihex_rec_if.source     out_rec
);
  import ihex_pkg::*;
  `include "assert_macros.svh"

  phase_t      phase_r,   phase_nxt;
  logic        second_r,  second_nxt;
  logic [3:0]  high_r,    high_nxt;
  logic [7:0]  sum_r,     sum_nxt;
  logic [7:0]  left_r,    left_nxt;
  logic [15:0] naddr_r,   naddr_nxt;
  logic [15:0] rstart_r,  rstart_nxt;
  logic        ended_r,   ended_nxt;

  logic        out_valid_r;
  kind_t       kind_r,    kind_nxt;
  logic [15:0] addr_r,    addr_nxt;
  logic [7:0]  data_r,    data_nxt;
  logic        bad_r;
  logic        emit;
  logic        advance;
  logic [7:0]  byte_val;

  assign pop_ready = !out_valid_r || out_rec.ready;
  assign advance   = pop_valid && pop_ready;
  assign byte_val  = {high_r, pop_tok.nib};

  always_comb begin
    phase_nxt  = phase_r;
    second_nxt = second_r;
    high_nxt   = high_r;
    sum_nxt    = sum_r;
    left_nxt   = left_r;
    naddr_nxt  = naddr_r;
    rstart_nxt = rstart_r;
    ended_nxt  = ended_r;
    emit       = 1'b0;
    kind_nxt   = K_BADDIGIT;
    data_nxt   = '0;
    if (advance && !ended_r) begin
      if (phase_r == PH_HUNT) begin
        if (pop_tok.colon) begin
          phase_nxt  = PH_LEN;
          sum_nxt    = '0;
          second_nxt = 1'b0;
          high_nxt   = '0;
          left_nxt   = '0;
        end
      end else if (!second_r) begin
        high_nxt   = pop_tok.nib;
        second_nxt = 1'b1;
      end else begin
        second_nxt = 1'b0;
        sum_nxt    = sum_r + byte_val;
        unique case (phase_r)
          PH_LEN: begin
            left_nxt  = byte_val;
            phase_nxt = PH_AHI;
          end
          PH_AHI: begin
            rstart_nxt = {byte_val, 8'h00};
            phase_nxt  = PH_ALO;
          end
          PH_ALO: begin
            rstart_nxt = {rstart_r[15:8], byte_val};
            naddr_nxt  = {rstart_r[15:8], byte_val};
            phase_nxt  = PH_TYPE;
          end
          PH_TYPE: begin
            if (byte_val == REC_TYPE_DATA) begin
              phase_nxt = (left_r != '0) ? PH_DATA : PH_CSUM;
            end else if (byte_val == REC_TYPE_EOF) begin
              ended_nxt = 1'b1;
              phase_nxt = PH_HUNT;
              emit      = 1'b1;
              kind_nxt  = K_END;
            end else begin
              phase_nxt = PH_HUNT;
              emit      = 1'b1;
              kind_nxt  = K_UNKNOWN;
            end
          end
          PH_DATA: begin
            emit      = 1'b1;
            kind_nxt  = K_DATA;
            data_nxt  = byte_val;
            naddr_nxt = naddr_r + 16'd1;
            left_nxt  = left_r - 8'd1;
            if (left_r == 8'd1) begin
              phase_nxt = PH_CSUM;
            end
          end
          PH_CSUM: begin
            phase_nxt = PH_HUNT;
            if (sum_nxt != '0) begin
              emit     = 1'b1;
              kind_nxt = K_CSUM;
            end
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
      // A bad digit with nothing else to report gets its own item.
      if (!emit && pop_tok.bad && phase_r != PH_HUNT) begin
        emit     = 1'b1;
        kind_nxt = K_BADDIGIT;
      end
    end
    addr_nxt = (kind_nxt == K_DATA) ? naddr_r : rstart_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      second_r    <= 1'b0;
      high_r      <= '0;
      sum_r       <= '0;
      left_r      <= '0;
      naddr_r     <= '0;
      rstart_r    <= '0;
      ended_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      second_r <= second_nxt;
      high_r   <= high_nxt;
      sum_r    <= sum_nxt;
      left_r   <= left_nxt;
      naddr_r  <= naddr_nxt;
      rstart_r <= rstart_nxt;
      ended_r  <= ended_nxt;
      if (advance) begin
        out_valid_r <= emit;
      end else if (out_rec.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      kind_r <= kind_nxt;
      addr_r <= addr_nxt;
      data_r <= data_nxt;
      bad_r  <= pop_tok.bad;
    end
  end

  assign out_rec.valid     = out_valid_r;
  assign out_rec.kind      = kind_r;
  assign out_rec.address   = addr_r;
  assign out_rec.data      = data_r;
  assign out_rec.digit_bad = bad_r;

  `IHEX_ASSERT(a_hunt_pair, clk, rst_n, !(phase_r == PH_HUNT && second_r), "half byte held while hunting")
  `IHEX_ASSERT_NEXT(a_quiet_end, clk, rst_n, ended_r && !out_valid_r, !out_valid_r, "result after end record")
  `IHEX_ASSERT_NEXT(a_data_left, clk, rst_n, phase_r == PH_DATA, left_r != '0 || phase_r != PH_DATA, "data phase with no bytes left")

endmodule

### hdl/intel_hex_record_decoder.sv
// Intel HEX record decoder top level: front classifier, token queue, record engine.
// Throughput: one character per cycle sustained while the result side keeps up.
// Each character is registered in the classifier, then written into the token
// queue, and any result it causes is registered at the output by the record engine.
// Reset (rst_n low, synchronous): queue empties, record engine returns to hunting
// for ':' with sum, length and addresses cleared and the end-of-file flag dropped.
module intel_hex_record_decoder (
  input  logic       clk,
  input  logic       rst_n,
  ihex_char_if.sink  in_ch,
  ihex_rec_if.source out_rec
);
  import ihex_pkg::*;

  // Classifier to queue.
  logic fq_valid;
  logic fq_ready;
  tok_t fq_tok;

  // Queue to record engine.
  logic qb_valid;
  logic qb_ready;
  tok_t qb_tok;

  // Classify each character: hex nibble, bad-digit flag and colon flag.
  ihex_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_tok   (fq_tok)
  );

  // Hold a couple of tokens so the classifier keeps taking items
  // while the engine waits on a stalled output.
  ihex_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_tok   (fq_tok),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_tok    (qb_tok)
  );

  // Advance the record phase, assemble bytes, keep the running sum,
  // and drive the registered result item.
  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_tok   (qb_tok),
    .out_rec   (out_rec)
  );

endmodule

### dv/ihex_record_checker.sv
// Checker for the intel hex record decoder: predicts each result and compares it.
module ihex_record_checker (
  input  logic clk,
  input  logic rst_n,
  ihex_char_if char_mon,
  ihex_rec_if  rec_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  data;
    logic        digit_bad;
  } hex_result_t;

  // Decoder state as the checker sees it.
  phase_t      rec_phase;
  logic        second_nib;
  logic [3:0]  high_nib;
  logic [7:0]  byte_sum;
  logic [7:0]  bytes_left;
  logic [15:0] next_addr;
  logic [15:0] rec_start;
  logic        eof_seen;

  hex_result_t expected_q[$];

  function automatic void queue_result(input kind_t k, input logic [15:0] a,
                                       input logic [7:0] d, input logic b);
    hex_result_t r;
    r.kind      = k;
    r.address   = a;
    r.data      = d;
    r.digit_bad = b;
    expected_q.push_back(r);
  endfunction

  // Advance the decoder state by one character and queue any result it causes.
  function automatic void decode_char(input logic [7:0] c);
    logic [7:0] val;
    logic [3:0] nib;
    logic       bad;
    logic       emitted;
    if (eof_seen) return;
    if (rec_phase == PH_HUNT) begin
      if (c == CH_COLON) begin
        rec_phase  = PH_LEN;
        byte_sum   = '0;
        second_nib = 1'b0;
        high_nib   = '0;
        bytes_left = '0;
      end
      return;
    end

    bad = 1'b0;
    val = '0;
    if (c >= CH_0 && c <= CH_9) val = c - CH_0;
    else if (c >= CH_UA && c <= CH_UF) val = c - CH_UA + HEX_TEN;
    else if (c >= CH_LA && c <= CH_LF) val = c - CH_LA + HEX_TEN;
    else bad = 1'b1;
    nib = val[3:0];

    if (!second_nib) begin
      high_nib   = nib;
      second_nib = 1'b1;
      if (bad) queue_result(K_BADDIGIT, rec_start, 8'h00, 1'b1);
      return;
    end

    val        = {high_nib, nib};
    second_nib = 1'b0;
    byte_sum   = byte_sum + val;
    emitted    = 1'b0;
    case (rec_phase)
      PH_LEN: begin
        bytes_left = val;
        rec_phase  = PH_AHI;
      end
      PH_AHI: begin
        rec_start = {val, 8'h00};
        rec_phase = PH_ALO;
      end
      PH_ALO: begin
        rec_start[7:0] = val;
        next_addr      = {rec_start[15:8], val};
        rec_phase      = PH_TYPE;
      end
      PH_TYPE: begin
        if (val == REC_TYPE_DATA) begin
          if (bytes_left != 8'd0) rec_phase = PH_DATA;
          else rec_phase = PH_CSUM;
        end else if (val == REC_TYPE_EOF) begin
          eof_seen  = 1'b1;
          rec_phase = PH_HUNT;
          queue_result(K_END, rec_start, 8'h00, bad);
          emitted = 1'b1;
        end else begin
          rec_phase = PH_HUNT;
          queue_result(K_UNKNOWN, rec_start, 8'h00, bad);
          emitted = 1'b1;
        end
      end
      PH_DATA: begin
        queue_result(K_DATA, next_addr, val, bad);
        emitted    = 1'b1;
        next_addr  = next_addr + 16'd1;
        bytes_left = bytes_left - 8'd1;
        if (bytes_left == 8'd0) rec_phase = PH_CSUM;
      end
      default: begin
        rec_phase = PH_HUNT;
        if (byte_sum != 8'd0) begin
          queue_result(K_CSUM, rec_start, 8'h00, bad);
          emitted = 1'b1;
        end
      end
    endcase
    if (bad && !emitted) queue_result(K_BADDIGIT, rec_start, 8'h00, 1'b1);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < PRINT_LIMIT)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    hex_result_t want;
    if (!rst_n) begin
      rec_phase  = PH_HUNT;
      second_nib = 1'b0;
      high_nib   = '0;
      byte_sum   = '0;
      bytes_left = '0;
      next_addr  = '0;
      rec_start  = '0;
      eof_seen   = 1'b0;
      expected_q.delete();
    end else begin
      if (char_mon.valid && char_mon.ready) decode_char(char_mon.char_in);
      if (rec_mon.valid && rec_mon.ready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with none pending (kind)", 32'(rec_mon.kind), 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (rec_mon.kind !== want.kind)
            report_mismatch("kind", 32'(rec_mon.kind), 32'(want.kind));
          if (rec_mon.address !== want.address)
            report_mismatch("address", 32'(rec_mon.address), 32'(want.address));
          if (rec_mon.data !== want.data)
            report_mismatch("data", 32'(rec_mon.data), 32'(want.data));
          if (rec_mon.digit_bad !== want.digit_bad)
            report_mismatch("digit_bad", 32'(rec_mon.digit_bad), 32'(want.digit_bad));
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

### dv/tb.sv
// Top of the intel hex record decoder testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ihex_pkg::*;

  localparam int HALF_PERIOD  = 5;
  localparam int RESET_CYCLES = 10;
  // Stop the random part once this many characters have gone in.
  localparam int RANDOM_CHARS = 1400;
  // Far above the slowest legal run: every character waiting out a full
  // sender gap and a full receiver stall, plus the pipeline.
  localparam int CYCLE_LIMIT  = 200000;
  // Two register stages plus the internal token queue.
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst_n;
  int   cycle_count;
  int   chars_sent;
  int   src_idle_pct;
  int   snk_idle_pct;
  int   fail_count;
  int   outstanding;

  ihex_char_if in_ch();
  ihex_rec_if  out_rec();

  intel_hex_record_decoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_rec (out_rec)
  );

  ihex_record_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_mon    (in_ch),
    .rec_mon     (out_rec),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #HALF_PERIOD clk = ~clk;

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: drop ready in random bursts, at the current stall rate.
  initial begin
    int stall_left;
    stall_left = 0;
    out_rec.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_rec.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < snk_idle_pct) begin
        out_rec.ready <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_rec.ready <= 1'b1;
      end
    end
  end

  function automatic bit is_hex(input logic [7:0] c);
    return (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UF) ||
           (c >= CH_LA && c <= CH_LF);
  endfunction

  // ASCII digit for a nibble, in upper or lower case.
  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
    if (nib < 4'd10) return CH_0 + {4'h0, nib};
    return (upper ? CH_UA : CH_LA) + {4'h0, nib} - HEX_TEN;
  endfunction

  // Any character the decoder must flag as a bad digit; ':' gets extra weight
  // since a colon inside a record must not restart it.
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) return CH_COLON;
    do c = 8'($urandom_range(0, 255)); while (is_hex(c));
    return c;
  endfunction

  // Offer one item; an optional idle burst comes first. Valid stays high
  // between back-to-back items, so it is never lowered and raised in one step.
  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.char_in <= c;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // One digit of a record; with bad_pct percent chance replace it by garbage.
  task automatic send_digit(input logic [3:0] nib, input int bad_pct);
    if ($urandom_range(0, 99) < bad_pct) send_char(non_hex_char());
    else send_char(hex_char(nib, 1'($urandom_range(0, 1))));
  endtask

  // Whole record with random payload. The checksum is correct unless sum_err
  // is set, in which case it is off by a nonzero amount.
  task automatic send_record(input int len, input logic [15:0] addr,
                             input logic [7:0] rtype, input bit sum_err,
                             input int bad_pct);
    logic [7:0] rec_bytes[$];
    logic [7:0] sum;
    logic [7:0] csum;
    rec_bytes = {len[7:0], addr[15:8], addr[7:0], rtype};
    for (int i = 0; i < len; i++) rec_bytes.push_back(8'($urandom_range(0, 255)));
    sum = '0;
    foreach (rec_bytes[i]) sum += rec_bytes[i];
    csum = -sum;
    if (sum_err) csum ^= 8'($urandom_range(1, 255));
    rec_bytes.push_back(csum);
    send_char(CH_COLON);
    foreach (rec_bytes[i]) begin
      send_digit(rec_bytes[i][7:4], bad_pct);
      send_digit(rec_bytes[i][3:0], bad_pct);
    end
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  initial begin
    int          pick;
    int          len;
    logic [15:0] addr;
    logic [7:0]  rtype;

    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.char_in <= 8'h00;
    src_idle_pct  = 15;
    snk_idle_pct  = 15;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Junk before any colon is skipped, whatever its value.
    send_char(8'h00);
    send_char(8'hFF);
    send_text("G\r\n");
    // Empty data record: the next byte is the checksum, nothing comes out.
    send_record(0, 16'h0000, REC_TYPE_DATA, 1'b0, 0);
    // Data crossing the top of the address space wraps to zero.
    send_record(2, 16'hFFFF, REC_TYPE_DATA, 1'b0, 0);
    send_record(1, 16'h1234, REC_TYPE_DATA, 1'b1, 0);
    // Unknown types: reported, then the rest of the record is skipped.
    send_record(0, 16'h8000, 8'hFF, 1'b0, 0);
    send_record(3, 16'h00FF, 8'h02, 1'b0, 0);
    // Bad first nibble on the length, then a colon completing a data byte,
    // then a wrong checksum.
    send_text(":G1001000");
    send_text("4:00\r\n");
    // Bad second nibble on the type byte of an empty record.
    send_text(":0000000G00");

    // Random part: mostly well-formed records with random content, the rest
    // broken records and noise. Idle rates change every few records so that
    // quiet stretches and busy stretches both occur.
    while (chars_sent < RANDOM_CHARS) begin
      if ($urandom_range(0, 7) == 0) begin
        src_idle_pct = pick_idle_pct();
        snk_idle_pct = pick_idle_pct();
      end
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 29) == 0) len = $urandom_range(0, 1) ? 255 : $urandom_range(128, 254);
      else len = $urandom_range(0, 16);
      if ($urandom_range(0, 4) == 0) addr = 16'hFFFF - 16'($urandom_range(0, 8));
      else addr = 16'($urandom_range(0, 65535));
      rtype = REC_TYPE_DATA;

      if (pick < 55) begin
        send_record(len, addr, rtype, 1'b0, 0);
      end else if (pick < 68) begin
        send_record(len, addr, rtype, 1'b1, 0);
      end else if (pick < 78) begin
        if ($urandom_range(0, 3) == 0) rtype = 8'hFF;
        else rtype = 8'($urandom_range(2, 254));
        send_record(len, addr, rtype, 1'($urandom_range(0, 1)), 0);
      end else if (pick < 90) begin
        send_record(len, addr, rtype, 1'($urandom_range(0, 1)), 6);
      end else begin
        // Noise, sometimes followed by a truncated record.
        repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1)) begin
          send_char(CH_COLON);
          repeat ($urandom_range(0, 7))
            send_char(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
        end
      end
      if ($urandom_range(0, 1)) send_text("\r\n");
    end

    // Final part at full rate: clean records, the end-of-file record, then
    // input that must be ignored, including a complete record.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (4) send_record($urandom_range(1, 16), 16'($urandom_range(0, 65535)),
                           REC_TYPE_DATA, 1'b0, 0);
    send_record($urandom_range(0, 4), 16'($urandom_range(0, 65535)), REC_TYPE_EOF,
                1'b0, 0);
    send_text(":0100000041BE\r\n");
    repeat (16) send_char(8'($urandom_range(0, 255)));
    in_ch.valid <= 1'b0;

    // Sample on the falling edge so the checker has settled for this cycle.
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/ihex_pkg.sv
hdl/ihex_ifs.sv
hdl/ihex_front.sv
hdl/ihex_queue.sv
hdl/ihex_back.sv
hdl/intel_hex_record_decoder.sv
dv/ihex_record_checker.sv
dv/tb.sv
